FILE: src/battery_level_classifier_defines.svh
// Assertion macros for the battery level classifier.
// Included by the top level; depends on nothing else.
`ifndef BATTERY_LEVEL_CLASSIFIER_DEFINES_SVH
`define BATTERY_LEVEL_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BLC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("battery level classifier: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("battery level classifier: next-cycle check failed");

`endif

FILE: src/blc_pkg.sv
// Shared constants for the battery level classifier.
// Used by the channel interfaces and the top level; depends on nothing.
package blc_pkg;

   // Default parameter values.
   localparam int ADC_BITS_DEFAULT  = 12;
   localparam int FRAC_BITS_DEFAULT = 8;

   // Integer millivolt bits of the filter state.
   localparam int MV_INT_BITS = 13;
   localparam int LEVEL_W     = 3;

   // Configuration register indexes and port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_SCALE  = 3'd0;
   localparam logic [2:0] REG_OFFSET = 3'd1;
   localparam logic [2:0] REG_ALPHA  = 3'd2;
   localparam logic [2:0] REG_LEVEL4 = 3'd3;
   localparam logic [2:0] REG_LEVEL3 = 3'd4;
   localparam logic [2:0] REG_LEVEL2 = 3'd5;
   localparam logic [2:0] REG_LEVEL1 = 3'd6;
   localparam logic [2:0] REG_HYST   = 3'd7;

   // Register widths.
   localparam int SCALE_W  = 18;
   localparam int OFFSET_W = 10;
   localparam int ALPHA_W  = 9;
   localparam int HYST_W   = 10;

   // Register reset values.
   localparam logic [SCALE_W-1:0]     SCALE_RESET  = 18'd105627;
   localparam logic [OFFSET_W-1:0]    OFFSET_RESET = 10'd200;
   localparam logic [ALPHA_W-1:0]     ALPHA_RESET  = 9'd26;
   localparam logic [MV_INT_BITS-1:0] LEVEL4_RESET = 13'd4100;
   localparam logic [MV_INT_BITS-1:0] LEVEL3_RESET = 13'd3900;
   localparam logic [MV_INT_BITS-1:0] LEVEL2_RESET = 13'd3800;
   localparam logic [MV_INT_BITS-1:0] LEVEL1_RESET = 13'd3700;
   localparam logic [HYST_W-1:0]      HYST_RESET   = 10'd50;

   // Unity weight of the moving average in Q8.
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   // Level codes.
   localparam logic [LEVEL_W-1:0] LEVEL_0        = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_1        = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2        = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_3        = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_4        = 3'd4;
   localparam logic [LEVEL_W-1:0] LEVEL_CHARGING = 3'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_NONE     = 3'd7;

endpackage

FILE: src/blc_req_if.sv
// Request channel of the battery level classifier: one sample and charger flag.
// Depends on blc_pkg.
interface blc_req_if
   import blc_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_sample;
   logic                charging;

   modport source (output valid, output adc_sample, output charging, input ready);
   modport sink (input valid, input adc_sample, input charging, output ready);
endinterface

FILE: src/blc_rsp_if.sv
// Result channel of the battery level classifier: level, filtered voltage, change flag.
// Depends on blc_pkg.
interface blc_rsp_if
   import blc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [LEVEL_W-1:0]     level;
   logic [MV_INT_BITS-1:0] filtered_mv;
   logic                   level_changed;

   modport source (output valid, output level, output filtered_mv, output level_changed,
                   input ready);
   modport sink (input valid, input level, input filtered_mv, input level_changed,
                 output ready);
endinterface

FILE: src/battery_level_classifier.sv
// Top level of the battery level classifier: sequencer, shared multiplier, CSRs.
// Depends on blc_pkg, blc_req_if, blc_rsp_if and battery_level_classifier_defines.svh.

// Each request carries one converter sample and a charger flag and yields one result:
// the battery level (0 to 4, or 5 while charging), the integer millivolts of the
// smoothed voltage and a flag that is set when the level differs from the last one
// reported. One request is worked on at a time and req.ready is high only between
// requests. One multiplier is shared for the gain, the new-sample weight and the
// old-value weight (one product per cycle), and one comparator walks the levels from
// 4 down to 1, one level a cycle. The first request after reset seeds the filter and
// skips the two weighting products. A finished result waits in the output register,
// so the next request is taken while it is not yet collected. If that result is
// still waiting when the next one is finished, the sequencer holds in its last step
// until the waiting result is taken.
`include "battery_level_classifier_defines.svh"

module battery_level_classifier
   import blc_pkg::*;
#(
   parameter int ADC_BITS  = ADC_BITS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   blc_req_if.sink               req,
   blc_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Derived widths.
   localparam int ACC_W   = MV_INT_BITS + FRAC_BITS;
   localparam int MUL_A_W = (ADC_BITS > ALPHA_W) ? ADC_BITS : ALPHA_W;
   localparam int MUL_B_W = (ACC_W > SCALE_W) ? ACC_W : SCALE_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int RAW_W   = PROD_W + 1;
   localparam int SUM_W   = ACC_W + ALPHA_W + 1;
   localparam int SHIFT   = 16 - FRAC_BITS;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam logic [SUM_W-1:0] ROUND   = SUM_W'(128);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_RAW,
      ST_WNEW,
      ST_WOLD,
      ST_AVG,
      ST_CLASS,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [SCALE_W-1:0]     scale_ff;
   logic [OFFSET_W-1:0]    offset_ff;
   logic [ALPHA_W-1:0]     alpha_ff;
   logic [MV_INT_BITS-1:0] level4_ff, level3_ff, level2_ff, level1_ff;
   logic [HYST_W-1:0]      hyst_ff;

   // Sequencer state and datapath registers.
   state_type              state_ff, state_in;
   logic [ADC_BITS-1:0]    adc_ff, adc_in;
   logic                   chg_ff, chg_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [ACC_W-1:0]       raw_ff, raw_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   primed_ff, primed_in;
   logic [LEVEL_W-1:0]     k_ff, k_in;
   logic [LEVEL_W-1:0]     lvl_ff, lvl_in;
   logic [LEVEL_W-1:0]     reported_ff, reported_in;
   logic [LEVEL_W-1:0]     hold_ff, hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]     rsp_level_ff, rsp_level_in;
   logic [MV_INT_BITS-1:0] rsp_mv_ff, rsp_mv_in;
   logic                   rsp_changed_ff, rsp_changed_in;

   // Shared multiplier operands and product.
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [PROD_W-1:0]      mul_p;
   logic [ALPHA_W-1:0]     alpha_eff;

   // Datapath intermediates.
   logic [RAW_W-1:0]       raw_sum;
   logic [ACC_W-1:0]       raw_sat;
   logic [SUM_W-1:0]       avg_total;
   logic [SUM_W-1:0]       avg_val;
   logic [MV_INT_BITS-1:0] thr_sel;
   logic [MV_INT_BITS-1:0] band;
   logic [MV_INT_BITS-1:0] bound_mv;
   logic                   hit;

   logic                   csr_write;

   // Configuration port: writes on the access phase, reads are combinational.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         offset_ff <= OFFSET_RESET;
         alpha_ff  <= ALPHA_RESET;
         level4_ff <= LEVEL4_RESET;
         level3_ff <= LEVEL3_RESET;
         level2_ff <= LEVEL2_RESET;
         level1_ff <= LEVEL1_RESET;
         hyst_ff   <= HYST_RESET;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            REG_SCALE:  scale_ff  <= csr_pwdata[SCALE_W-1:0];
            REG_OFFSET: offset_ff <= csr_pwdata[OFFSET_W-1:0];
            REG_ALPHA:  alpha_ff  <= csr_pwdata[ALPHA_W-1:0];
            REG_LEVEL4: level4_ff <= csr_pwdata[MV_INT_BITS-1:0];
            REG_LEVEL3: level3_ff <= csr_pwdata[MV_INT_BITS-1:0];
            REG_LEVEL2: level2_ff <= csr_pwdata[MV_INT_BITS-1:0];
            REG_LEVEL1: level1_ff <= csr_pwdata[MV_INT_BITS-1:0];
            REG_HYST:   hyst_ff   <= csr_pwdata[HYST_W-1:0];
            default:    hyst_ff   <= hyst_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_SCALE:  csr_prdata = CSR_DATA_W'(scale_ff);
         REG_OFFSET: csr_prdata = CSR_DATA_W'(offset_ff);
         REG_ALPHA:  csr_prdata = CSR_DATA_W'(alpha_ff);
         REG_LEVEL4: csr_prdata = CSR_DATA_W'(level4_ff);
         REG_LEVEL3: csr_prdata = CSR_DATA_W'(level3_ff);
         REG_LEVEL2: csr_prdata = CSR_DATA_W'(level2_ff);
         REG_LEVEL1: csr_prdata = CSR_DATA_W'(level1_ff);
         REG_HYST:   csr_prdata = CSR_DATA_W'(hyst_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Weight of the new sample, clamped to unity.
   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   // Multiplier operand selection by sequencer step.
   always_comb begin
      case (state_ff)
         ST_SCALE: begin
            mul_a = MUL_A_W'(adc_ff);
            mul_b = MUL_B_W'(scale_ff);
         end
         ST_WNEW: begin
            mul_a = MUL_A_W'(alpha_eff);
            mul_b = MUL_B_W'(raw_ff);
         end
         ST_WOLD: begin
            mul_a = MUL_A_W'(ALPHA_ONE - alpha_eff);
            mul_b = MUL_B_W'(acc_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Full-width product of the shared multiplier.
   assign mul_p = mul_a * mul_b;

   // Scaled sample plus offset, saturated to the filter range.
   assign raw_sum = RAW_W'(prod_ff >> SHIFT) + (RAW_W'(offset_ff) << FRAC_BITS);
   assign raw_sat = (raw_sum > RAW_W'(ACC_MAX)) ? ACC_MAX : raw_sum[ACC_W-1:0];

   // Weighted sum with rounding, then the Q8 shift back to filter format.
   assign avg_total = sum_ff + SUM_W'(prod_ff);
   assign avg_val   = avg_total >> 8;

   // Threshold for the level under test; the held level gets the hysteresis band.
   always_comb begin
      case (k_ff)
         LEVEL_4: thr_sel = level4_ff;
         LEVEL_3: thr_sel = level3_ff;
         LEVEL_2: thr_sel = level2_ff;
         default: thr_sel = level1_ff;
      endcase
   end

   assign band     = (hold_ff == k_ff) ? MV_INT_BITS'(hyst_ff) : '0;
   assign bound_mv = thr_sel - band;
   assign hit      = (band > thr_sel) || (acc_ff > (ACC_W'(bound_mv) << FRAC_BITS));

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      adc_in         = adc_ff;
      chg_in         = chg_ff;
      prod_in        = mul_p;
      raw_in         = raw_ff;
      sum_in         = sum_ff;
      acc_in         = acc_ff;
      primed_in      = primed_ff;
      k_in           = k_ff;
      lvl_in         = lvl_ff;
      reported_in    = reported_ff;
      hold_in        = hold_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp.ready;
      rsp_level_in   = rsp_level_ff;
      rsp_mv_in      = rsp_mv_ff;
      rsp_changed_in = rsp_changed_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               adc_in   = req.adc_sample;
               chg_in   = req.charging;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_RAW;
         end
         ST_RAW: begin
            raw_in = raw_sat;
            if (!primed_ff) begin
               acc_in    = raw_sat;
               primed_in = 1'b1;
               k_in      = LEVEL_4;
               state_in  = ST_CLASS;
            end else begin
               state_in = ST_WNEW;
            end
         end
         ST_WNEW: begin
            state_in = ST_WOLD;
         end
         ST_WOLD: begin
            sum_in   = SUM_W'(prod_ff) + ROUND;
            state_in = ST_AVG;
         end
         ST_AVG: begin
            acc_in   = (avg_val > SUM_W'(ACC_MAX)) ? ACC_MAX : avg_val[ACC_W-1:0];
            k_in     = LEVEL_4;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            // One level per cycle, from the top down; none found gives level 0.
            if (chg_ff) begin
               lvl_in   = LEVEL_CHARGING;
               state_in = ST_DONE;
            end else if (hit) begin
               lvl_in   = k_ff;
               state_in = ST_DONE;
            end else if (k_ff == LEVEL_1) begin
               lvl_in   = LEVEL_0;
               state_in = ST_DONE;
            end else begin
               k_in = k_ff - LEVEL_1;
            end
         end
         ST_DONE: begin
            // Load the output register once it is free or being emptied.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_level_in   = lvl_ff;
               rsp_mv_in      = acc_ff[FRAC_BITS +: MV_INT_BITS];
               rsp_changed_in = (lvl_ff != reported_ff);
               if (lvl_ff != reported_ff) begin
                  reported_in = lvl_ff;
                  hold_in     = lvl_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         primed_ff    <= 1'b0;
         reported_ff  <= LEVEL_0;
         hold_ff      <= LEVEL_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         primed_ff    <= primed_in;
         reported_ff  <= reported_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      adc_ff         <= adc_in;
      chg_ff         <= chg_in;
      prod_ff        <= prod_in;
      raw_ff         <= raw_in;
      sum_ff         <= sum_in;
      k_ff           <= k_in;
      lvl_ff         <= lvl_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_mv_ff      <= rsp_mv_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   // Channel outputs.
   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.level         = rsp_level_ff;
   assign rsp.filtered_mv   = rsp_mv_ff;
   assign rsp.level_changed = rsp_changed_ff;

   // An accepted request keeps the sequencer busy on the next cycle.
   `BLC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req.valid && req.ready, !req.ready)
   // A waiting result never carries a level code above charging.
   `BLC_ASSERT_IMP(a_level_range, clock, reset, rsp.valid, rsp.level <= LEVEL_CHARGING)
   // The waiting result always holds the most recently reported level.
   `BLC_ASSERT_IMP(a_report_tracks, clock, reset, rsp.valid, rsp.level == reported_ff)
   // The held level is either unset or equal to the reported level.
   `BLC_ASSERT_IMP(a_hold_consistent, clock, reset, 1'b1,
                   hold_ff == LEVEL_NONE || hold_ff == reported_ff)

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the battery level classifier: a per-request predictor,
// a result checker and directed plus randomized request streams over several CSR settings.
// Depends on blc_pkg, blc_req_if, blc_rsp_if and the battery_level_classifier RTL.
module tb_top
   import blc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FRAC        = FRAC_BITS_DEFAULT;
   localparam logic [63:0] ACC_LIMIT   = (64'd1 << (MV_INT_BITS + FRAC)) - 64'd1;
   localparam int          STALL_LIMIT = 3000;
   localparam int          PHASES      = 12;
   localparam int          PHASE_ITEMS = 95;

   typedef struct packed {
      logic [LEVEL_W-1:0]     level;
      logic [MV_INT_BITS-1:0] filtered_mv;
      logic                   level_changed;
   } battery_report_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   blc_req_if req_ch ();
   blc_rsp_if rsp_ch ();

   battery_level_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the CSRs.
   logic [SCALE_W-1:0]     gain_q16;
   logic [OFFSET_W-1:0]    offset_mv;
   logic [ALPHA_W-1:0]     alpha_q8;
   logic [MV_INT_BITS-1:0] level_mv [1:4];
   logic [HYST_W-1:0]      hyst_mv;

   // Shadow copy of the gauge state.
   logic [MV_INT_BITS+FRAC-1:0] smooth_acc;
   logic                        seeded;
   logic [LEVEL_W-1:0]          last_level;
   logic [LEVEL_W-1:0]          held_level;

   battery_report_type expected_reports[$];
   int  mismatch_count = 0;
   int  stall_cycles = 0;
   bit  quiet;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // True when the filter state lies above a threshold lowered by a band.
   function automatic bit exceeds(logic [MV_INT_BITS+FRAC-1:0] acc,
                                  logic [MV_INT_BITS-1:0] thr, logic [HYST_W-1:0] band);
      longint bound;
      bound = (longint'(thr) - longint'(band)) * (longint'(1) << FRAC);
      return longint'(acc) > bound;
   endfunction

   // Advances the shadow gauge by one sample and returns the report it yields.
   function automatic battery_report_type grade_sample(logic [11:0] adc, logic chg);
      logic [63:0]        raw;
      logic [63:0]        mix;
      logic [ALPHA_W-1:0] weight;
      logic [LEVEL_W-1:0] lvl;
      battery_report_type rep;
      raw = ((64'(adc) * 64'(gain_q16)) >> (16 - FRAC)) + (64'(offset_mv) << FRAC);
      if (raw > ACC_LIMIT) raw = ACC_LIMIT;
      // The first sample seeds the filter; later ones blend in by alpha.
      if (!seeded) begin
         smooth_acc = raw[MV_INT_BITS+FRAC-1:0];
         seeded = 1'b1;
      end else begin
         weight = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
         mix = (64'(weight) * raw + 64'(ALPHA_ONE - weight) * 64'(smooth_acc) + 64'd128) >> 8;
         if (mix > ACC_LIMIT) mix = ACC_LIMIT;
         smooth_acc = mix[MV_INT_BITS+FRAC-1:0];
      end
      // Levels are tried from the top down; the held level gets the hysteresis band.
      if (chg) begin
         lvl = LEVEL_CHARGING;
      end else begin
         lvl = LEVEL_0;
         for (int k = 4; k >= 1; k--) begin
            if (exceeds(smooth_acc, level_mv[k], '0) ||
                (held_level == LEVEL_W'(k) && exceeds(smooth_acc, level_mv[k], hyst_mv))) begin
               lvl = LEVEL_W'(k);
               break;
            end
         end
      end
      rep.level_changed = (lvl != last_level);
      if (lvl != last_level) begin
         last_level = lvl;
         held_level = lvl;
      end
      rep.level = lvl;
      rep.filtered_mv = smooth_acc[MV_INT_BITS+FRAC-1:FRAC];
      return rep;
   endfunction

   // Sends one request after a random gap and records its expected report.
   task automatic send_sample(input logic [11:0] adc, input logic chg);
      int gap;
      battery_report_type rep;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.adc_sample <= adc;
      req_ch.charging   <= chg;
      do @(posedge clock); while (!req_ch.ready);
      rep = grade_sample(adc, chg);
      expected_reports = {expected_reports, rep};
      @(negedge clock);
   endtask

   // Holds off new requests until every expected report has come back.
   task automatic drain_reports();
      req_ch.valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // One APB write: setup phase, access phase, then idle.
   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SCALE:  gain_q16    = value[SCALE_W-1:0];
         REG_OFFSET: offset_mv   = value[OFFSET_W-1:0];
         REG_ALPHA:  alpha_q8    = value[ALPHA_W-1:0];
         REG_LEVEL4: level_mv[4] = value[MV_INT_BITS-1:0];
         REG_LEVEL3: level_mv[3] = value[MV_INT_BITS-1:0];
         REG_LEVEL2: level_mv[2] = value[MV_INT_BITS-1:0];
         REG_LEVEL1: level_mv[1] = value[MV_INT_BITS-1:0];
         REG_HYST:   hyst_mv     = value[HYST_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Reset settings: the first sample seeds the filter, then charging and the extremes.
   task automatic test_reset_settings();
      send_sample(12'd2600, 1'b0);
      send_sample(12'd4095, 1'b0);
      send_sample(12'd0, 1'b1);
      send_sample(12'd2500, 1'b0);
   endtask

   // One-to-one gain and an unfiltered path, so each sample lands on a chosen level.
   task automatic test_level_hysteresis();
      drain_reports();
      csr_write(REG_SCALE, 32'd65536);
      csr_write(REG_OFFSET, 32'd0);
      csr_write(REG_ALPHA, 32'(ALPHA_ONE));
      csr_write(REG_LEVEL4, 32'd3000);
      csr_write(REG_LEVEL3, 32'd2000);
      csr_write(REG_LEVEL2, 32'd1000);
      csr_write(REG_LEVEL1, 32'd500);
      csr_write(REG_HYST, 32'd100);
      send_sample(12'd3100, 1'b0);
      send_sample(12'd2950, 1'b0);
      send_sample(12'd2890, 1'b0);
      send_sample(12'd2950, 1'b0);
      send_sample(12'd1950, 1'b0);
      send_sample(12'd1890, 1'b0);
      send_sample(12'd400, 1'b0);
      send_sample(12'd4095, 1'b0);
      send_sample(12'd0, 1'b0);
      send_sample(12'd4095, 1'b1);
      send_sample(12'd4095, 1'b0);
   endtask

   // Saturation, zero gain, a band wider than its threshold, odd alphas, unordered levels.
   task automatic test_config_extremes();
      drain_reports();
      csr_write(REG_SCALE, 32'(2 ** SCALE_W - 1));
      csr_write(REG_OFFSET, 32'(2 ** OFFSET_W - 1));
      send_sample(12'd4095, 1'b0);
      send_sample(12'd0, 1'b0);
      drain_reports();
      csr_write(REG_SCALE, 32'd0);
      csr_write(REG_OFFSET, 32'd0);
      send_sample(12'd4095, 1'b0);
      // The held level survives any voltage once the band exceeds the threshold.
      drain_reports();
      csr_write(REG_SCALE, 32'd65536);
      csr_write(REG_HYST, 32'(2 ** HYST_W - 1));
      send_sample(12'd600, 1'b0);
      send_sample(12'd0, 1'b0);
      // Zero alpha freezes the filter; alpha beyond unity acts as unity.
      drain_reports();
      csr_write(REG_ALPHA, 32'd0);
      send_sample(12'd3500, 1'b0);
      drain_reports();
      csr_write(REG_ALPHA, 32'd300);
      send_sample(12'd3500, 1'b0);
      // Unordered thresholds: the fixed top-down order decides.
      drain_reports();
      csr_write(REG_LEVEL4, 32'd100);
      csr_write(REG_LEVEL3, 32'(2 ** MV_INT_BITS - 1));
      csr_write(REG_LEVEL2, 32'(2 ** MV_INT_BITS - 1));
      csr_write(REG_LEVEL1, 32'(2 ** MV_INT_BITS - 1));
      csr_write(REG_HYST, 32'd0);
      send_sample(12'd50, 1'b0);
      send_sample(12'd200, 1'b0);
   endtask

   // Settings per phase, extreme in the first two and random after, with thresholds placed
   // where the samples can reach them, and a drifting sample stream with charger bursts.
   task automatic test_random_sweeps();
      int          cur;
      int          pts[$];
      logic [63:0] raw;
      logic        chg;
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_reports();
         quiet = (phase % 4 == 3);
         if (phase == 0) begin
            csr_write(REG_SCALE, 32'(2 ** SCALE_W - 1));
            csr_write(REG_OFFSET, 32'(2 ** OFFSET_W - 1));
            csr_write(REG_ALPHA, 32'(ALPHA_ONE));
            csr_write(REG_HYST, 32'(2 ** HYST_W - 1));
         end else if (phase == 1) begin
            csr_write(REG_SCALE, 32'd0);
            csr_write(REG_OFFSET, 32'd0);
            csr_write(REG_ALPHA, 32'd1);
            csr_write(REG_HYST, 32'd0);
         end else begin
            case ($urandom_range(0, 3))
               0: csr_write(REG_SCALE, 32'(2 ** SCALE_W - 1));
               1: csr_write(REG_SCALE, 32'(SCALE_RESET));
               default: csr_write(REG_SCALE, $urandom_range(40000, 200000));
            endcase
            csr_write(REG_OFFSET, $urandom_range(0, 2 ** OFFSET_W - 1));
            case ($urandom_range(0, 4))
               0: csr_write(REG_ALPHA, 32'(ALPHA_ONE));
               1: csr_write(REG_ALPHA, 32'd1);
               default: csr_write(REG_ALPHA, $urandom_range(8, 256));
            endcase
            case ($urandom_range(0, 9))
               0: csr_write(REG_HYST, 32'd0);
               1: csr_write(REG_HYST, 32'(2 ** HYST_W - 1));
               default: csr_write(REG_HYST, $urandom_range(1, 200));
            endcase
         end
         // Thresholds at the voltages of four random samples, sorted unless scrambled.
         pts.delete();
         for (int i = 0; i < 4; i++) begin
            raw = ((64'(12'($urandom)) * 64'(gain_q16)) >> (16 - FRAC)) +
                  (64'(offset_mv) << FRAC);
            if (raw > ACC_LIMIT) raw = ACC_LIMIT;
            pts = {pts, int'(raw >> FRAC)};
         end
         if (phase % 6 != 5) pts.rsort();
         csr_write(REG_LEVEL4, 32'(pts[0]));
         csr_write(REG_LEVEL3, 32'(pts[1]));
         csr_write(REG_LEVEL2, 32'(pts[2]));
         csr_write(REG_LEVEL1, 32'(pts[3]));
         cur = $urandom_range(0, 4095);
         chg = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0) cur = $urandom_range(0, 4095);
            else cur = cur + $urandom_range(0, 128) - 64;
            if (cur < 0) cur = 0;
            if (cur > 4095) cur = 4095;
            if ($urandom_range(0, 14) == 0) chg = ~chg;
            send_sample(12'(cur), chg);
            if ($urandom_range(0, 39) == 0) drain_reports();
         end
      end
      quiet = 1'b0;
   endtask

   // Response side back-pressure.
   initial begin : rsp_backpressure
      int hold_off;
      hold_off = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) hold_off = pick_gap();
         end
      end
   end

   // Each accepted report is compared with the oldest expectation.
   always @(posedge clock) begin : check_reports
      battery_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: report with no request pending: level %0d, mv %0d, changed %0d",
                     $time, rsp_ch.level, rsp_ch.filtered_mv, rsp_ch.level_changed);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_ch.level !== want.level) begin
               $display("%0t: level mismatch: expected %0d, actual %0d",
                        $time, want.level, rsp_ch.level);
               mismatch_count++;
            end
            if (rsp_ch.filtered_mv !== want.filtered_mv) begin
               $display("%0t: filtered_mv mismatch: expected %0d, actual %0d",
                        $time, want.filtered_mv, rsp_ch.filtered_mv);
               mismatch_count++;
            end
            if (rsp_ch.level_changed !== want.level_changed) begin
               $display("%0t: level_changed mismatch: expected %0d, actual %0d",
                        $time, want.level_changed, rsp_ch.level_changed);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[battery_level_classifier] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Main sequence.
   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.adc_sample = '0;
      req_ch.charging = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      gain_q16 = SCALE_RESET;
      offset_mv = OFFSET_RESET;
      alpha_q8 = ALPHA_RESET;
      level_mv[4] = LEVEL4_RESET;
      level_mv[3] = LEVEL3_RESET;
      level_mv[2] = LEVEL2_RESET;
      level_mv[1] = LEVEL1_RESET;
      hyst_mv = HYST_RESET;
      smooth_acc = '0;
      seeded = 1'b0;
      last_level = LEVEL_0;
      held_level = LEVEL_NONE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_settings();
      test_level_hysteresis();
      test_config_extremes();
      test_random_sweeps();

      drain_reports();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[battery_level_classifier] OK");
      end else begin
         $display("[battery_level_classifier] ERROR");
      end
      $finish;
   end

endmodule
